// ===== src/open_addressing_hash_set_macros.svh =====
// Assertion macros for the open addressing hash set.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef OPEN_ADDRESSING_HASH_SET_MACROS_SVH
`define OPEN_ADDRESSING_HASH_SET_MACROS_SVH

`ifndef ASSERT_OFF

`define OHS_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define OHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define OHS_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)

`define OHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/ohs_pkg.sv =====
// Shared constants, codes and controller/datapath word types for the hash set.
// No dependencies.
package ohs_pkg;

   localparam int FUNC_W        = 2;
   localparam int KEY_W         = 64;
   localparam int LEN_W         = 4;
   localparam int MAX_KEY_CHARS = 8;
   localparam int IDX_W         = 6;
   localparam int CAPACITY      = 1 << IDX_W;
   localparam int STEP_W        = IDX_W + 1;
   localparam int HASH_MULT     = 271;
   localparam int LOAD_LIMIT    = 3 * ((CAPACITY + 3) / 4);
   localparam int CNT_W         = $clog2(LOAD_LIMIT + 1);
   localparam int BSEL_W        = $clog2(KEY_W / 8);

   typedef enum logic [FUNC_W-1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_FIND   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_EMPTY    = 2'd0,
      ST_DELETED  = 2'd1,
      ST_OCCUPIED = 2'd2
   } slot_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HASH,
      S_READ,
      S_CHECK,
      S_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic hash_step;
      logic probe_start;
      logic read;
      logic check;
      logic commit;
   } ohs_cmd_type;

   typedef struct packed {
      logic hash_done;
      logic probe_done;
   } ohs_sts_type;

endpackage

// ===== src/ohs_ctrl.sv =====
// Request sequencer for the hash set: hashing, probe read/check loop, commit.
// Depends on ohs_pkg.
module ohs_ctrl import ohs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  ohs_sts_type sts,
   output ohs_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_HASH;
         S_HASH:   if (sts.hash_done) state_in = S_READ;
         S_READ:   state_in = S_CHECK;
         S_CHECK:  state_in = sts.probe_done ? S_FINISH : S_READ;
         S_FINISH: if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_HASH: begin
            cmd.hash_step   = 1'b1;
            cmd.probe_start = sts.hash_done;
         end
         S_READ:   cmd.read   = 1'b1;
         S_CHECK:  cmd.check  = 1'b1;
         S_FINISH: cmd.commit = out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== src/ohs_dpath.sv =====
// Hash set datapath: key latch, hash, probe index walk, slot memories, results.
// Depends on ohs_pkg and open_addressing_hash_set_macros.svh.
`include "open_addressing_hash_set_macros.svh"

module ohs_dpath import ohs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ohs_cmd_type       cmd,
   output ohs_sts_type       sts,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [KEY_W-1:0]  req_key_chars,
   input  logic [LEN_W-1:0]  req_key_length,
   output logic              rsp_ok,
   output logic              rsp_table_full
);

   // slot memories; status entries are qualified by per-slot valid bits
   slot_status_type              status_mem [CAPACITY];
   logic [LEN_W+KEY_W-1:0]       key_mem    [CAPACITY];
   logic [CAPACITY-1:0]          slot_valid_ff;

   logic [FUNC_W-1:0]            func_ff;
   logic [KEY_W-1:0]             chars_ff, chars_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   logic [LEN_W-1:0]             kpos_ff;
   logic [IDX_W-1:0]             hash_ff;
   logic [IDX_W-1:0]             idx_ff, sq_ff, cur_idx_ff, probe_idx;
   logic [STEP_W-1:0]            step_ff;
   logic                         hit_found_ff, free_found_ff;
   logic [IDX_W-1:0]             hit_idx_ff, free_idx_ff;
   logic [CNT_W-1:0]             count_ff;
   logic                         rsp_ok_ff, rsp_table_full_ff;

   slot_status_type              rd_status_ff, cur_status;
   logic [LEN_W+KEY_W-1:0]       rd_key_ff;
   logic                         rd_valid_ff;

   logic [BSEL_W-1:0]            byte_sel;
   logic [7:0]                   cur_char;
   logic                         is_hit, slot_free;

   logic                         wr_en, key_wr, cnt_inc, ok_in, full_in;
   logic [IDX_W-1:0]             wr_idx;
   slot_status_type              wr_status;

   // key clamp and masking of unused characters
   always_comb begin
      len_in = (req_key_length > LEN_W'(MAX_KEY_CHARS)) ? LEN_W'(MAX_KEY_CHARS)
                                                         : req_key_length;
      for (int b = 0; b < KEY_W / 8; b++) begin
         chars_in[b*8 +: 8] = (LEN_W'(b) < len_in) ? req_key_chars[b*8 +: 8] : 8'h00;
      end
   end

   assign byte_sel  = BSEL_W'(kpos_ff);
   assign cur_char  = chars_ff[{byte_sel, 3'b000} +: 8];
   assign probe_idx = idx_ff + sq_ff;

   assign cur_status = rd_valid_ff ? rd_status_ff : ST_EMPTY;
   assign is_hit     = (cur_status == ST_OCCUPIED) && (rd_key_ff == {len_ff, chars_ff});
   assign slot_free  = (cur_status == ST_EMPTY) || (cur_status == ST_DELETED);

   assign sts.hash_done  = (kpos_ff == len_ff);
   assign sts.probe_done = (cur_status == ST_EMPTY) || is_hit
                           || (step_ff == STEP_W'(CAPACITY));

   // outcome of the finished probe
   always_comb begin
      wr_en     = 1'b0;
      key_wr    = 1'b0;
      cnt_inc   = 1'b0;
      ok_in     = 1'b0;
      full_in   = 1'b0;
      wr_idx    = free_idx_ff;
      wr_status = ST_OCCUPIED;
      unique case (func_ff)
         OP_INSERT: begin
            if (!hit_found_ff) begin
               if (count_ff >= CNT_W'(LOAD_LIMIT) || !free_found_ff) begin
                  full_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  key_wr  = 1'b1;
                  cnt_inc = 1'b1;
                  ok_in   = 1'b1;
               end
            end
         end
         OP_ERASE: begin
            if (hit_found_ff) begin
               wr_en     = 1'b1;
               wr_idx    = hit_idx_ff;
               wr_status = ST_DELETED;
               ok_in     = 1'b1;
            end
         end
         OP_FIND: ok_in = hit_found_ff;
         default: ok_in = 1'b0;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         count_ff      <= '0;
      end else if (cmd.commit) begin
         if (wr_en) slot_valid_ff[wr_idx] <= 1'b1;
         if (cnt_inc) count_ff <= count_ff + 1'b1;
      end
   end

   // request, hash and probe registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         chars_ff <= chars_in;
         len_ff   <= len_in;
         kpos_ff  <= '0;
         hash_ff  <= '0;
      end else if (cmd.hash_step && (kpos_ff != len_ff)) begin
         hash_ff <= IDX_W'(hash_ff * IDX_W'(HASH_MULT)) + IDX_W'(cur_char);
         kpos_ff <= kpos_ff + 1'b1;
      end
      if (cmd.probe_start) begin
         idx_ff        <= hash_ff;
         sq_ff         <= '0;
         step_ff       <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.read) begin
         idx_ff     <= probe_idx;
         cur_idx_ff <= probe_idx;
         sq_ff      <= sq_ff + {step_ff[IDX_W-2:0], 1'b1};
         step_ff    <= step_ff + 1'b1;
      end else if (cmd.check) begin
         if (is_hit) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= cur_idx_ff;
         end
         if (slot_free && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= cur_idx_ff;
         end
      end
      if (cmd.commit) begin
         rsp_ok_ff         <= ok_in;
         rsp_table_full_ff <= full_in;
      end
   end

   // slot memories
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) status_mem[wr_idx] <= wr_status;
      if (cmd.commit && key_wr) key_mem[wr_idx] <= {len_ff, chars_ff};
      if (cmd.read) begin
         rd_status_ff <= status_mem[probe_idx];
         rd_key_ff    <= key_mem[probe_idx];
         rd_valid_ff  <= slot_valid_ff[probe_idx];
      end
   end

   assign rsp_ok         = rsp_ok_ff;
   assign rsp_table_full = rsp_table_full_ff;

   `OHS_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(LOAD_LIMIT), "insert count past load limit")
   `OHS_ASSERT_ALWAYS(a_step_bound, clock, reset, !cmd.check || step_ff <= STEP_W'(CAPACITY), "probe ran past capacity")
   `OHS_ASSERT_NEXT(a_write_valid, clock, reset, cmd.commit && wr_en, slot_valid_ff[$past(wr_idx)], "written slot not valid")

endmodule

// ===== src/open_addressing_hash_set.sv =====
// Open addressing hash set of keys up to 8 characters: insert, erase, find.
// One word in gives one word out. A request hashes its key one character per
// cycle over L, the clamped key length, then probes P slots (1 to 64); each
// probe is a read and then a check on the single registered read port of the
// slot memories, and the insert's free-slot search rides along the same probe
// pass. One request is in work at a time; the next is taken while a result
// waits in the output register.
// Depends on ohs_pkg, ohs_ctrl and ohs_dpath.
module open_addressing_hash_set import ohs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [KEY_W-1:0]  req_key_chars,
   input  logic [LEN_W-1:0]  req_key_length,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_ok,
   output logic              rsp_table_full
);

   ohs_cmd_type cmd;
   ohs_sts_type sts;

   ohs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ohs_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_func),
      .req_key_chars  (req_key_chars),
      .req_key_length (req_key_length),
      .rsp_ok         (rsp_ok),
      .rsp_table_full (rsp_table_full)
   );

endmodule
